### rtl/psp_pkg.sv
// Shared widths, pipeline depths and codes of the point-to-segment proximity block.
`timescale 1ns / 1ps
package psp_pkg;

    localparam int COORD_W = 32;
    localparam int TOL_W   = COORD_W - 1;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int NUM_W   = 2 * DIFF_W + 2;
    localparam int DEN_W   = 2 * DIFF_W + 1;
    localparam int CROSS_W = 2 * DIFF_W + 1;
    localparam int TOL2_W  = 2 * TOL_W;

    localparam int MW      = NUM_W;
    localparam int PW      = 2 * MW;
    localparam int LIMB    = (MW + 3) / 3;
    localparam int MAGX_W  = 3 * LIMB;

    localparam int Q_W     = DIFF_W + 3;
    localparam int MAG_W   = DEN_W + Q_W - 3;
    localparam int SUM_W   = Q_W + 3;

    localparam int MUL_LAT = 5;
    localparam int DIV_LAT = Q_W;
    localparam int P_S1    = 1 + MUL_LAT;
    localparam int P_S2    = P_S1 + 1 + MUL_LAT;
    localparam int P_OUT   = P_S2 + 1 + DIV_LAT;
    localparam int NSTG    = P_OUT + 1;

    localparam int M1_N    = 13;
    localparam int M2_N    = 7;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_X = 3'd0,
        CFG_FIRST_Y = 3'd1,
        CFG_FIRST_Z = 3'd2,
        CFG_LAST_X  = 3'd3,
        CFG_LAST_Y  = 3'd4,
        CFG_LAST_Z  = 3'd5,
        CFG_TOL     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic degen;
        logic near_seg;
        logic near_line;
        logic span;
    } t_flags;

endpackage

### rtl/point_segment_proximity_3d_top.sv
// Top level of the 3D point-to-segment proximity pipeline.
`timescale 1ns / 1ps
// Each beat carries one query point and yields one result beat. The pipeline takes a new
// point every cycle while the output does not stall; the pipeline depth is set by two rounds
// of five-stage multipliers and by the 36-stage divider that forms the projection
// quotient. A stall at the output freezes the whole pipeline. Segment and tolerance
// registers reset to a zero-length segment and a tolerance of one and must be written
// only while no beat is in flight.
module point_segment_proximity_3d_top
    import psp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [COORD_W-1:0]    i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // point_x, point_y, point_z
    input  logic [3*COORD_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // proj_x, proj_y, proj_z, within_span, near_line, near_segment, degenerate, zero pad
    output logic [3*COORD_W+7:0]  o_m_tdata
);

    logic signed [COORD_W-1:0] r_first [3];
    logic signed [COORD_W-1:0] r_last  [3];
    logic [TOL_W-1:0]          r_tol;

    logic                      en;
    logic [NSTG-1:0]           r_vld;

    logic signed [DIFF_W-1:0]  r_b [3];
    logic signed [DIFF_W-1:0]  r_u [3];

    logic signed [MW-1:0]      m1_a [M1_N];
    logic signed [MW-1:0]      m1_b [M1_N];
    logic signed [PW-1:0]      m1_p [M1_N];
    logic signed [MW-1:0]      m2_a [M2_N];
    logic signed [MW-1:0]      m2_b [M2_N];
    logic signed [PW-1:0]      m2_p [M2_N];

    logic signed [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]          r_den;
    logic signed [CROSS_W-1:0] r_c [3];
    logic [TOL2_W-1:0]         r_tol2;
    logic signed [NUM_W-1:0]   r_num_d [MUL_LAT];
    logic [DEN_W-1:0]          r_den_d [MUL_LAT];

    logic [PW-1:0]             sq;
    logic [PW+1:0]             lhs;
    logic [PW+1:0]             rhs;
    logic                      span;
    logic                      degen;
    t_flags                    n_flg;
    t_flags                    r_flg;
    logic [2:0]                r_neg;
    logic [MAG_W-1:0]          r_mag [3];
    logic [DEN_W-1:0]          r_den2;
    t_flags                    r_flg_d [DIV_LAT];
    logic [2:0]                r_neg_d [DIV_LAT];

    logic [Q_W-1:0]            dq   [3];
    logic [DEN_W-1:0]          drem [3];
    logic [DEN_W-1:0]          dden [3];

    logic signed [COORD_W-1:0] n_proj [3];
    logic signed [COORD_W-1:0] r_proj [3];
    t_flags                    r_oflg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_first[i] <= '0;
                r_last[i]  <= '0;
            end
            r_tol <= TOL_W'(1);
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_FIRST_X: r_first[0] <= i_cfg_wdata;
                CFG_FIRST_Y: r_first[1] <= i_cfg_wdata;
                CFG_FIRST_Z: r_first[2] <= i_cfg_wdata;
                CFG_LAST_X:  r_last[0]  <= i_cfg_wdata;
                CFG_LAST_Y:  r_last[1]  <= i_cfg_wdata;
                CFG_LAST_Z:  r_last[2]  <= i_cfg_wdata;
                CFG_TOL:     r_tol      <= i_cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    assign en         = !r_vld[NSTG-1] || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_b[i] <= DIFF_W'($signed(i_s_tdata[i*COORD_W +: COORD_W]))
                        - DIFF_W'(r_first[i]);
                r_u[i] <= DIFF_W'(r_last[i]) - DIFF_W'(r_first[i]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m1_a[i]     = MW'(r_b[i]);
            m1_b[i]     = MW'(r_u[i]);
            m1_a[3 + i] = MW'(r_u[i]);
            m1_b[3 + i] = MW'(r_u[i]);
        end
        m1_a[6]  = MW'(r_b[1]); m1_b[6]  = MW'(r_u[2]);
        m1_a[7]  = MW'(r_b[2]); m1_b[7]  = MW'(r_u[1]);
        m1_a[8]  = MW'(r_b[2]); m1_b[8]  = MW'(r_u[0]);
        m1_a[9]  = MW'(r_b[0]); m1_b[9]  = MW'(r_u[2]);
        m1_a[10] = MW'(r_b[0]); m1_b[10] = MW'(r_u[1]);
        m1_a[11] = MW'(r_b[1]); m1_b[11] = MW'(r_u[0]);
        m1_a[12] = MW'(r_tol);  m1_b[12] = MW'(r_tol);
    end

    for (genvar g = 0; g < M1_N; g++) begin : g_m1
        psp_mul u_mul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (m1_a[g]),
            .i_b   (m1_b[g]),
            .o_p   (m1_p[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num  <= NUM_W'(m1_p[0]) + NUM_W'(m1_p[1]) + NUM_W'(m1_p[2]);
            r_den  <= DEN_W'(m1_p[3]) + DEN_W'(m1_p[4]) + DEN_W'(m1_p[5]);
            r_c[0] <= CROSS_W'(m1_p[6]) - CROSS_W'(m1_p[7]);
            r_c[1] <= CROSS_W'(m1_p[8]) - CROSS_W'(m1_p[9]);
            r_c[2] <= CROSS_W'(m1_p[10]) - CROSS_W'(m1_p[11]);
            r_tol2 <= TOL2_W'(m1_p[12]);
            for (int k = 0; k < MUL_LAT; k++) begin
                r_num_d[k] <= (k == 0) ? r_num : r_num_d[k-1];
                r_den_d[k] <= (k == 0) ? r_den : r_den_d[k-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m2_a[i]     = MW'(r_u[i]);
            m2_b[i]     = r_num;
            m2_a[3 + i] = MW'(r_c[i]);
            m2_b[3 + i] = MW'(r_c[i]);
        end
        m2_a[6] = MW'(r_tol2);
        m2_b[6] = MW'(r_den);
    end

    for (genvar g = 0; g < M2_N; g++) begin : g_m2
        psp_mul u_mul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (m2_a[g]),
            .i_b   (m2_b[g]),
            .o_p   (m2_p[g])
        );
    end

    always_comb begin
        sq    = $unsigned(m2_p[3]) + $unsigned(m2_p[4]) + $unsigned(m2_p[5]);
        lhs   = {sq, 2'b00};
        rhs   = (PW + 2)'($unsigned(m2_p[6]));
        degen = (r_den_d[MUL_LAT-1] == '0);
        span  = !r_num_d[MUL_LAT-1][NUM_W-1]
             && ($unsigned(r_num_d[MUL_LAT-1]) <= NUM_W'(r_den_d[MUL_LAT-1]));
        n_flg.degen     = degen;
        n_flg.span      = !degen && span;
        n_flg.near_line = !degen && (lhs < rhs);
        n_flg.near_seg  = !degen && span && (lhs <= rhs);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flg  <= n_flg;
            r_den2 <= r_den_d[MUL_LAT-1];
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= m2_p[i][PW-1];
                r_mag[i] <= m2_p[i][PW-1] ? MAG_W'(-m2_p[i]) : MAG_W'(m2_p[i]);
            end
            for (int k = 0; k < DIV_LAT; k++) begin
                r_flg_d[k] <= (k == 0) ? r_flg : r_flg_d[k-1];
                r_neg_d[k] <= (k == 0) ? r_neg : r_neg_d[k-1];
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        psp_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_mag (r_mag[g]),
            .i_den (r_den2),
            .o_q   (dq[g]),
            .o_rem (drem[g]),
            .o_den (dden[g])
        );
    end

    always_comb begin
        logic [Q_W:0]              qr;
        logic signed [Q_W+1:0]     sv;
        logic signed [SUM_W-1:0]   s;
        logic signed [SUM_W-1:0]   sat_hi;
        logic signed [SUM_W-1:0]   sat_lo;
        sat_hi = SUM_W'((64'd1 << (COORD_W - 1)) - 64'd1);
        sat_lo = -sat_hi - SUM_W'(1);
        for (int i = 0; i < 3; i++) begin
            qr = (Q_W + 1)'(dq[i]) + (Q_W + 1)'({drem[i], 1'b0} >= {1'b0, dden[i]});
            sv = r_neg_d[DIV_LAT-1][i] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
            s  = SUM_W'(r_first[i]) + SUM_W'(sv);
            if (r_flg_d[DIV_LAT-1].degen) begin
                n_proj[i] = r_first[i];
            end else if (s > sat_hi) begin
                n_proj[i] = COORD_W'(sat_hi);
            end else if (s < sat_lo) begin
                n_proj[i] = COORD_W'(sat_lo);
            end else begin
                n_proj[i] = COORD_W'(s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oflg <= r_flg_d[DIV_LAT-1];
            for (int i = 0; i < 3; i++) begin
                r_proj[i] <= n_proj[i];
            end
        end
    end

    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = {4'b0000, r_oflg.degen, r_oflg.near_seg, r_oflg.near_line,
                         r_oflg.span, r_proj[2], r_proj[1], r_proj[0]};

`ifndef ASSERT_OFF
    a_degen_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oflg.degen |-> !r_oflg.span && !r_oflg.near_line && !r_oflg.near_seg)
        else $error("degenerate result carries a set test flag");
    a_seg_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flg.near_seg |-> r_flg.span)
        else $error("near_segment set outside the span");
    a_line_span_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flg.near_line && r_flg.span) |-> r_flg.near_seg)
        else $error("near_line inside the span without near_segment");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");
`endif

endmodule

### rtl/psp_mul.sv
// Five-stage signed multiplier built from 23-bit limbs and their 46-bit partial products.
`timescale 1ns / 1ps
module psp_mul
    import psp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [MW-1:0] i_a,
    input  logic signed [MW-1:0] i_b,
    output logic signed [PW-1:0] o_p
);

    logic [MW-1:0]       n_ma;
    logic [MW-1:0]       n_mb;
    logic [MAGX_W-1:0]   r_ma;
    logic [MAGX_W-1:0]   r_mb;
    logic [3:0]          r_sg;
    logic [2*LIMB-1:0]   r_pp [3][3];
    logic [PW-1:0]       r_row [3];
    logic [PW-1:0]       r_sum;
    logic signed [PW-1:0] r_p;

    assign n_ma = i_a[MW-1] ? MW'(-i_a) : MW'(i_a);
    assign n_mb = i_b[MW-1] ? MW'(-i_b) : MW'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma  <= MAGX_W'(n_ma);
            r_mb  <= MAGX_W'(n_mb);
            r_sg  <= {r_sg[2:0], i_a[MW-1] ^ i_b[MW-1]};
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pp[i][j] <= r_ma[i*LIMB +: LIMB] * r_mb[j*LIMB +: LIMB];
                end
                r_row[i] <= PW'(r_pp[i][0]) + (PW'(r_pp[i][1]) << LIMB)
                          + (PW'(r_pp[i][2]) << (2 * LIMB));
            end
            r_sum <= r_row[0] + (r_row[1] << LIMB) + (r_row[2] << (2 * LIMB));
            r_p   <= r_sg[3] ? -$signed(r_sum) : $signed(r_sum);
        end
    end

    assign o_p = r_p;

endmodule

### rtl/psp_div.sv
// Pipelined restoring divider that retires one quotient bit per stage.
`timescale 1ns / 1ps
module psp_div
    import psp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [MAG_W-1:0] i_mag,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_q,
    output logic [DEN_W-1:0] o_rem,
    output logic [DEN_W-1:0] o_den
);

    logic [DEN_W-1:0] r_rem [DIV_LAT];
    logic [Q_W-1:0]   r_lo  [DIV_LAT];
    logic [Q_W-1:0]   r_q   [DIV_LAT];
    logic [DEN_W-1:0] r_den [DIV_LAT];
    logic [DEN_W-1:0] n_rem [DIV_LAT];
    logic             n_bit [DIV_LAT];

    always_comb begin
        logic [DEN_W-1:0] s_rem;
        logic [Q_W-1:0]   s_lo;
        logic [DEN_W-1:0] s_den;
        logic [DEN_W:0]   trial;
        for (int k = 0; k < DIV_LAT; k++) begin
            if (k == 0) begin
                s_rem = DEN_W'(i_mag[MAG_W-1:Q_W]);
                s_lo  = i_mag[Q_W-1:0];
                s_den = i_den;
            end else begin
                s_rem = r_rem[k-1];
                s_lo  = r_lo[k-1];
                s_den = r_den[k-1];
            end
            trial    = {s_rem, s_lo[Q_W-1]};
            n_bit[k] = (trial >= {1'b0, s_den});
            n_rem[k] = n_bit[k] ? DEN_W'(trial - {1'b0, s_den}) : DEN_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_rem[k] <= n_rem[k];
                if (k == 0) begin
                    r_lo[k]  <= {i_mag[Q_W-2:0], 1'b0};
                    r_q[k]   <= Q_W'(n_bit[k]);
                    r_den[k] <= i_den;
                end else begin
                    r_lo[k]  <= {r_lo[k-1][Q_W-2:0], 1'b0};
                    r_q[k]   <= {r_q[k-1][Q_W-2:0], n_bit[k]};
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_q   = r_q[DIV_LAT-1];
    assign o_rem = r_rem[DIV_LAT-1];
    assign o_den = r_den[DIV_LAT-1];

endmodule

### tb/tb_point_segment_proximity_3d_top.sv
// Self-checking testbench of the 3D point-to-segment proximity pipeline.
`timescale 1ns / 1ps
module tb_point_segment_proximity_3d_top;
    import psp_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic [COORD_W-1:0] proj_x;
        logic [COORD_W-1:0] proj_y;
        logic [COORD_W-1:0] proj_z;
        logic               span;
        logic               near_line;
        logic               near_seg;
        logic               degen;
    } proximity_t;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int HOLD_CYCLES    = 400;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wen;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COORD_W-1:0]   i_cfg_wdata;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [3*COORD_W-1:0] i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [3*COORD_W+7:0] o_m_tdata;

    point_segment_proximity_3d_top DUT (.*);

    logic [COORD_W-1:0] seg_first [3];
    logic [COORD_W-1:0] seg_last [3];
    logic [TOL_W-1:0]   seg_tol;

    logic [3*COORD_W-1:0] point_q [$];
    proximity_t           expect_q [$];
    int  src_idle_pct;
    int  snk_stall_pct;
    logic point_taken;
    logic hold_go;
    int  hold_cnt;
    int  mismatches;
    int  quiet_cycles;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [COORD_W-1:0] saturate(wide_t s);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (COORD_W - 1)) - 1;
        lo = -(hi + 1);
        if (s > hi) s = hi;
        if (s < lo) s = lo;
        return s[COORD_W-1:0];
    endfunction

    function automatic proximity_t project_point(logic [3*COORD_W-1:0] pt);
        proximity_t res;
        wide_t f [3];
        wide_t u [3];
        wide_t b [3];
        wide_t c [3];
        wide_t num, den, t, mag, q, r, sq, lhs, rhs, tol;
        logic neg;
        for (int i = 0; i < 3; i++) begin
            f[i] = $signed(seg_first[i]);
            u[i] = wide_t'($signed(seg_last[i])) - f[i];
            b[i] = wide_t'($signed(pt[i*COORD_W +: COORD_W])) - f[i];
        end
        num = b[0] * u[0] + b[1] * u[1] + b[2] * u[2];
        den = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
        if (den == 0) begin
            res.proj_x = seg_first[0];
            res.proj_y = seg_first[1];
            res.proj_z = seg_first[2];
            res.span = 1'b0;
            res.near_line = 1'b0;
            res.near_seg = 1'b0;
            res.degen = 1'b1;
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            t = u[i] * num;
            neg = t < 0;
            mag = neg ? -t : t;
            q = mag / den;
            r = mag % den;
            if (2 * r >= den) q = q + 1;
            if (neg) q = -q;
            case (i)
                0: res.proj_x = saturate(f[i] + q);
                1: res.proj_y = saturate(f[i] + q);
                default: res.proj_z = saturate(f[i] + q);
            endcase
        end
        c[0] = b[1] * u[2] - b[2] * u[1];
        c[1] = b[2] * u[0] - b[0] * u[2];
        c[2] = b[0] * u[1] - b[1] * u[0];
        sq = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
        lhs = sq <<< 2;
        tol = wide_t'({1'b0, seg_tol});
        rhs = tol * tol * den;
        res.span = (num >= 0) && (num <= den);
        res.near_line = lhs < rhs;
        res.near_seg = res.span && (lhs <= rhs);
        res.degen = 1'b0;
        return res;
    endfunction

    task automatic add_point(logic [3*COORD_W-1:0] pt);
        point_q = {point_q, pt};
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        if (idx < CFG_LAST_X) seg_first[idx] = val;
        else if (idx < CFG_TOL) seg_last[idx - CFG_LAST_X] = val;
        else if (idx == CFG_TOL) seg_tol = val[TOL_W-1:0];
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic set_segment(logic [COORD_W-1:0] fx, logic [COORD_W-1:0] fy,
                               logic [COORD_W-1:0] fz, logic [COORD_W-1:0] lx,
                               logic [COORD_W-1:0] ly, logic [COORD_W-1:0] lz,
                               logic [TOL_W-1:0] tol);
        write_reg(CFG_FIRST_X, fx);
        write_reg(CFG_FIRST_Y, fy);
        write_reg(CFG_FIRST_Z, fz);
        write_reg(CFG_LAST_X, lx);
        write_reg(CFG_LAST_Y, ly);
        write_reg(CFG_LAST_Z, lz);
        write_reg(CFG_TOL, {1'b0, tol});
    endtask

    task automatic wait_idle();
        while (point_q.size() != 0 || expect_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [3*COORD_W-1:0] pack_point(longint x, longint y, longint z);
        return {z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
    endfunction

    // Points near the line (and often on the segment) with random spread around it.
    function automatic logic [3*COORD_W-1:0] near_point();
        longint p [3];
        longint s;
        longint j;
        s = longint'($urandom_range(1280)) - 128;
        j = (seg_tol / 2 < 64) ? longint'(seg_tol / 2) + 2 : 64;
        if ($urandom_range(3) == 0) j = longint'(seg_tol) + 2;
        for (int i = 0; i < 3; i++) begin
            p[i] = longint'($signed(seg_first[i])) +
                   (longint'($signed(seg_last[i])) - longint'($signed(seg_first[i]))) * s / 1024 +
                   longint'($urandom_range(32'(2 * j))) - j;
        end
        return pack_point(p[0], p[1], p[2]);
    endfunction

    function automatic logic [3*COORD_W-1:0] random_point();
        case ($urandom_range(9))
            0: return {$urandom, $urandom, $urandom};
            1: return {seg_last[2], seg_last[1], seg_last[0]};
            2: return {seg_first[2], seg_first[1], seg_first[0]};
            default: return near_point();
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] small_coord();
        return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
    endfunction

    // Source side: whenever the current point is taken or none is shown, offers the next one unless it idles at random.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || point_taken)) begin
            if (point_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= point_q.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n)
            i_m_tready <= (hold_cnt == 0) && ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        if (hold_go) hold_cnt <= HOLD_CYCLES;
        else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    end

    always @(posedge i_clk) begin
        proximity_t got;
        proximity_t exp_r;
        point_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) expect_q = {expect_q, project_point(i_s_tdata)};
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.proj_x = o_m_tdata[0 +: COORD_W];
            got.proj_y = o_m_tdata[COORD_W +: COORD_W];
            got.proj_z = o_m_tdata[2*COORD_W +: COORD_W];
            got.span = o_m_tdata[3*COORD_W];
            got.near_line = o_m_tdata[3*COORD_W+1];
            got.near_seg = o_m_tdata[3*COORD_W+2];
            got.degen = o_m_tdata[3*COORD_W+3];
            if (expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result beat: %p", got);
            end else begin
                exp_r = expect_q.pop_front();
                if (got.proj_x !== exp_r.proj_x || got.proj_y !== exp_r.proj_y ||
                    got.proj_z !== exp_r.proj_z || got.span !== exp_r.span ||
                    got.near_line !== exp_r.near_line || got.near_seg !== exp_r.near_seg ||
                    got.degen !== exp_r.degen) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result mismatch: expected %p, got %p", exp_r, got);
                end
            end
        end
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("point_segment_proximity_3d_top regression: fail");
            $finish;
        end
    end

    initial begin
        int mode;
        i_rst_n = 1'b0;
        i_cfg_wen = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        hold_go = 1'b0;
        hold_cnt = 0;
        point_taken = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        for (int i = 0; i < 3; i++) begin
            seg_first[i] = '0;
            seg_last[i] = '0;
        end
        seg_tol = 1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The reset segment has zero length.
        add_point(pack_point(5, -7, 9));
        add_point({32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000});
        wait_idle();

        set_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '1);
        write_reg(CFG_UNUSED, 32'h1234_5678);
        add_point({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        add_point({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        add_point({32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
        add_point({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
        add_point('0);
        add_point({32'hffff_ffff, 32'h0000_0001, 32'h0000_0000});
        wait_idle();

        // Zero tolerance: only exact points on the segment pass.
        set_segment(0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, '0);
        add_point(pack_point(32'h0000_8000, 32'h0001_0000, 32'h0001_8000));
        add_point(pack_point(32'h0000_8000, 32'h0001_0000, 32'h0001_8001));
        add_point(pack_point(32'h0002_0000, 32'h0004_0000, 32'h0006_0000));
        add_point(pack_point(-32'sh0001_0000, -32'sh0002_0000, -32'sh0003_0000));
        add_point(pack_point(0, 0, 0));
        wait_idle();
        write_reg(CFG_TOL, 32'd2);
        add_point(pack_point(1, 0, 0));
        add_point(pack_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0001));
        add_point(pack_point(32'h0001_0001, 32'h0002_0000, 32'h0003_0000));
        add_point(pack_point(32'h0000_0001, 32'h0000_0002, 32'h0000_0003));
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            mode = ph % 4;
            src_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 64 : 24) : 0;
            snk_stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 64 : 24) : 0;
            case (ph)
                3: set_segment({$urandom}, {$urandom}, {$urandom},
                               {$urandom}, {$urandom}, {$urandom}, TOL_W'($urandom));
                5: set_segment(small_coord(), small_coord(), small_coord(),
                               small_coord(), small_coord(), small_coord(), '0);
                6: set_segment(32'h7fff_0000, small_coord(), 32'h8000_0000,
                               32'h8000_1000, small_coord(), 32'h7fff_ffff, '1);
                default: set_segment(small_coord(), small_coord(), small_coord(),
                                     small_coord(), small_coord(), small_coord(),
                                     TOL_W'($urandom_range(32'h0004_0000)));
            endcase
            if (ph == 7) write_reg(CFG_LAST_Y, seg_first[1]);
            for (int n = 0; n < 110; n++) add_point(random_point());
            if (ph == 1) begin
                @(negedge i_clk);
                hold_go <= 1'b1;
                @(negedge i_clk);
                hold_go <= 1'b0;
            end
            while (point_q.size() != 0) @(negedge i_clk);
            if (ph == 2) while (expect_q.size() != 0) @(negedge i_clk);
            for (int n = 0; n < 105; n++) add_point(random_point());
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("point_segment_proximity_3d_top regression: pass");
        end else begin
            $display("point_segment_proximity_3d_top regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/psp_pkg.sv
rtl/psp_mul.sv
rtl/psp_div.sv
rtl/point_segment_proximity_3d_top.sv
tb/tb_point_segment_proximity_3d_top.sv
